### src/rfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

    localparam int ID_BITS       = 22;
    localparam int INTEREST_BITS = 320;
    localparam int WORD_BITS     = 32;
    localparam int PAGE_SIZE     = 32;
    localparam int WORD_IDX_BITS = $clog2(WORD_BITS);
    localparam int CNT_BITS      = 6;
    localparam int IDX_BITS      = 9;
    localparam int REG_IDX_BITS  = 3;
    localparam int ADDR_BITS     = REG_IDX_BITS + 2;
    localparam int APB_BITS      = 32;

    localparam logic [1:0] SEX_ANY = 2'd2;
    localparam logic [1:0] ORI_ANY = 2'd0;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_AGE_LOW         = 3'd0,
        REG_AGE_HIGH        = 3'd1,
        REG_LOCATION_FILTER = 3'd2,
        REG_CATEGORY_MATCH  = 3'd3,
        REG_INTEREST_INDEX  = 3'd4,
        REG_SKIP_COUNT      = 3'd5,
        REG_PAGE_LIMIT      = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic                 first_record;
        logic [ID_BITS-1:0]   user_id;
        logic [15:0]          user_location;
        logic [7:0]           user_age;
        logic                 user_sex;
        logic [1:0]           user_active;
        logic [1:0]           user_pic;
        logic                 user_single;
        logic [1:0]           user_orientation;
        logic [WORD_BITS-1:0] interest_word;
    } t_rec;

    typedef struct packed {
        logic                matched;
        logic                emit;
        logic [ID_BITS-1:0]  result_id;
        logic [ID_BITS-1:0]  total_matched;
        logic [CNT_BITS-1:0] returned_count;
    } t_res;

    typedef struct packed {
        logic [7:0]          age_low;
        logic [7:0]          age_high;
        logic [15:0]         location_filter;
        logic [8:0]          category_match;
        logic [IDX_BITS-1:0] interest_index;
        logic [ID_BITS-1:0]  skip_count;
        logic [CNT_BITS-1:0] page_limit;
    } t_cfg;

    // classified record handed from front to back
    typedef struct packed {
        logic               first_record;
        logic [ID_BITS-1:0] user_id;
        logic               matched;
    } t_cls;

endpackage

`default_nettype wire

### src/rfp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rfp_in_if import rfp_pkg::*; ();
    logic valid;
    logic ready;
    t_rec data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/rfp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rfp_out_if import rfp_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/rfp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module rfp_cfg import rfp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [APB_BITS-1:0]  pwdata,
    output logic      [APB_BITS-1:0]  prdata,
    output logic                      pready,
    output t_cfg                      o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_AGE_LOW:         n_cfg.age_low         = pwdata[7:0];
                REG_AGE_HIGH:        n_cfg.age_high        = pwdata[7:0];
                REG_LOCATION_FILTER: n_cfg.location_filter = pwdata[15:0];
                REG_CATEGORY_MATCH:  n_cfg.category_match  = pwdata[8:0];
                REG_INTEREST_INDEX:  n_cfg.interest_index  = pwdata[IDX_BITS-1:0];
                REG_SKIP_COUNT:      n_cfg.skip_count      = pwdata[ID_BITS-1:0];
                REG_PAGE_LIMIT:      n_cfg.page_limit      = pwdata[CNT_BITS-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_AGE_LOW:         prdata = APB_BITS'(r_cfg.age_low);
            REG_AGE_HIGH:        prdata = APB_BITS'(r_cfg.age_high);
            REG_LOCATION_FILTER: prdata = APB_BITS'(r_cfg.location_filter);
            REG_CATEGORY_MATCH:  prdata = APB_BITS'(r_cfg.category_match);
            REG_INTEREST_INDEX:  prdata = APB_BITS'(r_cfg.interest_index);
            REG_SKIP_COUNT:      prdata = APB_BITS'(r_cfg.skip_count);
            REG_PAGE_LIMIT:      prdata = APB_BITS'(r_cfg.page_limit);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.age_low         <= 8'd0;
            r_cfg.age_high        <= 8'd255;
            r_cfg.location_filter <= 16'd0;
            r_cfg.category_match  <= 9'd2;
            r_cfg.interest_index  <= '0;
            r_cfg.skip_count      <= '0;
            r_cfg.page_limit      <= CNT_BITS'(25);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### src/rfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rfp_front import rfp_pkg::*; (
    rfp_in_if.sink     i_rec,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_ready,
    output logic       o_push,
    output t_cls       o_cls
);

    logic [1:0] w_want_sex;
    logic [1:0] w_want_ori;
    logic       w_age_ok;
    logic       w_loc_ok;
    logic       w_sex_ok;
    logic       w_lvl_ok;
    logic       w_ori_ok;
    logic       w_int_ok;

    assign w_want_sex = i_cfg.category_match[1:0];
    assign w_want_ori = i_cfg.category_match[3:2];

    assign w_age_ok = (i_rec.data.user_age >= i_cfg.age_low) &&
                      (i_rec.data.user_age <= i_cfg.age_high);
    assign w_loc_ok = (i_cfg.location_filter == '0) ||
                      (i_rec.data.user_location == i_cfg.location_filter);
    // selector 3 never equals a one-bit sex, so it rejects everything
    assign w_sex_ok = (w_want_sex == SEX_ANY) ||
                      ({1'b0, i_rec.data.user_sex} == w_want_sex);
    assign w_lvl_ok = (i_rec.data.user_active >= i_cfg.category_match[5:4]) &&
                      (i_rec.data.user_pic    >= i_cfg.category_match[7:6]) &&
                      (i_rec.data.user_single >= i_cfg.category_match[8]);
    assign w_ori_ok = (w_want_ori == ORI_ANY) ||
                      (i_rec.data.user_orientation == w_want_ori);
    assign w_int_ok = (i_cfg.interest_index == '0) ||
                      ((i_cfg.interest_index < IDX_BITS'(INTEREST_BITS)) &&
                       i_rec.data.interest_word[
                           i_cfg.interest_index[WORD_IDX_BITS-1:0]]);

    assign i_rec.ready        = i_q_ready;
    assign o_push             = i_rec.valid && i_q_ready;
    assign o_cls.first_record = i_rec.data.first_record;
    assign o_cls.user_id      = i_rec.data.user_id;
    assign o_cls.matched      = w_age_ok && w_loc_ok && w_sex_ok &&
                                w_lvl_ok && w_ori_ok && w_int_ok;

endmodule

`default_nettype wire

### src/rfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module rfp_queue import rfp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_ready,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cls      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(DEPTH)) |-> !i_push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !i_pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

### src/rfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rfp_back import rfp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_q_valid,
    input  wire t_cls  i_cls,
    output logic       o_pop,
    rfp_out_if.source  o_res
);

    localparam logic [ID_BITS-1:0] MATCH_MAX = '1;

    logic [ID_BITS-1:0]  r_match;
    logic [CNT_BITS-1:0] r_emitted;
    logic                r_valid;
    t_res                r_res;

    logic [ID_BITS-1:0]  w_base_m;
    logic [CNT_BITS-1:0] w_base_e;
    logic [CNT_BITS-1:0] w_limit;
    logic [ID_BITS-1:0]  n_match;
    logic [CNT_BITS-1:0] n_emitted;
    logic                w_emit;

    assign o_pop       = i_q_valid && (!r_valid || o_res.ready);
    assign o_res.valid = r_valid;
    assign o_res.data  = r_res;

    always_comb begin
        w_base_m = i_cls.first_record ? '0 : r_match;
        w_base_e = i_cls.first_record ? '0 : r_emitted;
        w_limit  = (i_cfg.page_limit > CNT_BITS'(PAGE_SIZE)) ?
                   CNT_BITS'(PAGE_SIZE) : i_cfg.page_limit;
        n_match  = w_base_m;
        if (i_cls.matched && (w_base_m != MATCH_MAX)) begin
            n_match = w_base_m + 1'b1;
        end
        w_emit    = i_cls.matched && (n_match >= i_cfg.skip_count) &&
                    (w_base_e < w_limit);
        n_emitted = w_emit ? w_base_e + 1'b1 : w_base_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match   <= '0;
            r_emitted <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_match   <= n_match;
                r_emitted <= n_emitted;
                r_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.matched        <= i_cls.matched;
            r_res.emit           <= w_emit;
            r_res.result_id      <= w_emit ? i_cls.user_id : '0;
            r_res.total_matched  <= n_match;
            r_res.returned_count <= n_emitted;
        end
    end

    a_emit_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (!r_res.emit || r_res.matched))
        else $error("word emitted without a match");

    a_page_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= CNT_BITS'(PAGE_SIZE))
        else $error("emitted count beyond page size");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.total_matched == r_match &&
                     r_res.returned_count == r_emitted))
        else $error("result word out of step with counters");

endmodule

`default_nettype wire

### src/record_filter_pager_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted record is written into the classify queue, then popped into the output
//   register, from which its result word is offered.
// Throughput: one record per cycle while the receiver holds ready, set by the counter update in the back end.
// Reset (synchronous, active low): config to defaults, counters zero, queue and output empty.

module record_filter_pager_unit import rfp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rfp_in_if.sink                    i_rec,
    rfp_out_if.source                 o_res,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [APB_BITS-1:0]  pwdata,
    output logic      [APB_BITS-1:0]  prdata,
    output logic                      pready
);

    t_cfg w_cfg;
    t_cls w_push_cls;
    t_cls w_pop_cls;
    logic w_push;
    logic w_q_ready;
    logic w_q_valid;
    logic w_pop;

    rfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rfp_front u_front (
        .i_rec     (i_rec),
        .i_cfg     (w_cfg),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cls     (w_push_cls)
    );

    rfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cls),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_pop_cls)
    );

    rfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_cls     (w_pop_cls),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

### sim/tb_record_filter_pager_unit.sv
`timescale 1ns / 1ps

module tb_record_filter_pager_unit;
    import rfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum bit {ROW_CFG, ROW_REC} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_reg_idx    reg_idx;
        logic [31:0] val;
        t_rec        rec;
        bit          typed;
        t_res        res;
    } t_row;

    typedef struct {
        bit   typed;
        t_res res;
    } t_pinned;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [APB_BITS-1:0]  pwdata;
    logic [APB_BITS-1:0]  prdata;
    logic                 pready;

    rfp_in_if  rec_if ();
    rfp_out_if res_if ();

    record_filter_pager_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter settings and scan counters as the block should hold them
    t_cfg                cfg;
    logic [ID_BITS-1:0]  match_count;
    logic [CNT_BITS-1:0] emitted_count;

    t_res    results_due[$];
    t_pinned pinned_results[$];
    t_row    dir_rows[$];
    int      errors;
    int      cyc_cnt;
    int      burst_left;

    always #5 i_clk = ~i_clk;

    function automatic bit record_hits(t_rec r);
        logic [1:0] want_sex;
        logic [1:0] want_ori;
        logic [1:0] min_act;
        logic [1:0] min_pic;
        logic       min_sgl;
        want_sex = cfg.category_match[1:0];
        want_ori = cfg.category_match[3:2];
        min_act  = cfg.category_match[5:4];
        min_pic  = cfg.category_match[7:6];
        min_sgl  = cfg.category_match[8];
        if (r.user_age < cfg.age_low || r.user_age > cfg.age_high) return 1'b0;
        if (cfg.location_filter != 0 && r.user_location != cfg.location_filter) return 1'b0;
        if (want_sex != SEX_ANY && {1'b0, r.user_sex} != want_sex) return 1'b0;
        if (r.user_active < min_act || r.user_pic < min_pic || r.user_single < min_sgl)
            return 1'b0;
        if (want_ori != ORI_ANY && r.user_orientation != want_ori) return 1'b0;
        if (cfg.interest_index != 0) begin
            if (cfg.interest_index >= INTEREST_BITS) return 1'b0;
            if (!r.interest_word[cfg.interest_index % WORD_BITS]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_res filter_record(t_rec r);
        t_res                res;
        logic [CNT_BITS-1:0] lim;
        bit                  hit;
        res = '0;
        if (r.first_record) begin
            match_count   = '0;
            emitted_count = '0;
        end
        lim = (cfg.page_limit > PAGE_SIZE) ? CNT_BITS'(PAGE_SIZE) : cfg.page_limit;
        hit = record_hits(r);
        if (hit) begin
            if (match_count != '1) match_count++;
            if (match_count >= cfg.skip_count && emitted_count < lim) begin
                res.emit      = 1'b1;
                res.result_id = r.user_id;
                emitted_count++;
            end
        end
        res.matched        = hit;
        res.total_matched  = match_count;
        res.returned_count = emitted_count;
        return res;
    endfunction

    function automatic t_rec mk_rec(bit first, logic [ID_BITS-1:0] id, logic [15:0] loc,
                                    logic [7:0] age, bit sex, logic [1:0] act,
                                    logic [1:0] pic, bit sgl, logic [1:0] ori,
                                    logic [31:0] word);
        t_rec r;
        r.first_record     = first;
        r.user_id          = id;
        r.user_location    = loc;
        r.user_age         = age;
        r.user_sex         = sex;
        r.user_active      = act;
        r.user_pic         = pic;
        r.user_single      = sgl;
        r.user_orientation = ori;
        r.interest_word    = word;
        return r;
    endfunction

    function automatic t_res mk_res(bit m, bit e, logic [ID_BITS-1:0] id,
                                    logic [ID_BITS-1:0] tot, logic [CNT_BITS-1:0] cnt);
        t_res res;
        res.matched        = m;
        res.emit           = e;
        res.result_id      = id;
        res.total_matched  = tot;
        res.returned_count = cnt;
        return res;
    endfunction

    function automatic void add_cfg(t_reg_idx idx, logic [31:0] val);
        t_row row;
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.val     = val;
        row.rec     = '0;
        row.typed   = 1'b0;
        row.res     = '0;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_rec(t_rec r, bit typed, t_res res);
        t_row row;
        row.kind    = ROW_REC;
        row.reg_idx = REG_AGE_LOW;
        row.val     = '0;
        row.rec     = r;
        row.typed   = typed;
        row.res     = res;
        dir_rows.push_back(row);
    endfunction

    task automatic build_table();
        // defaults after reset: everything matches, skip 0, page 25
        add_rec(mk_rec(1'b0, 22'h3FFFFF, 16'hFFFF, 8'd255, 1'b1, 2'd3, 2'd3, 1'b1, 2'd3,
                       32'hFFFF_FFFF), 1'b1, mk_res(1'b1, 1'b1, 22'h3FFFFF, 1, 1));
        add_rec(mk_rec(1'b0, 0, 0, 0, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b1, 0, 2, 2));
        add_rec(mk_rec(1'b1, 22'd123456, 16'd77, 8'd0, 1'b0, 2'd1, 2'd2, 1'b0, 2'd1,
                       32'h8000_0001), 1'b1, mk_res(1'b1, 1'b1, 22'd123456, 1, 1));
        // age window edges
        add_cfg(REG_AGE_LOW, 32'd20);
        add_cfg(REG_AGE_HIGH, 32'd30);
        add_rec(mk_rec(1'b1, 22'h2AAAAA, 16'd5, 8'd19, 1'b1, 2'd3, 2'd3, 1'b1, 2'd2,
                       32'h5555_5555), 1'b1, '0);
        add_rec(mk_rec(1'b0, 22'h155555, 16'd5, 8'd20, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd1001, 16'd5, 8'd30, 1'b1, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd1002, 16'd5, 8'd31, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        add_cfg(REG_AGE_HIGH, 32'd255);
        add_cfg(REG_AGE_LOW, 32'd255);
        add_rec(mk_rec(1'b1, 22'd42, 16'd9, 8'd255, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b1, 22'd42, 1, 1));
        // empty age range
        add_cfg(REG_AGE_LOW, 32'd40);
        add_cfg(REG_AGE_HIGH, 32'd39);
        add_rec(mk_rec(1'b1, 22'd43, 16'd9, 8'd40, 1'b1, 0, 0, 1'b0, 0, 0), 1'b1, '0);
        add_cfg(REG_AGE_LOW, 32'd0);
        add_cfg(REG_AGE_HIGH, 32'd255);
        add_cfg(REG_LOCATION_FILTER, 32'd65535);
        add_rec(mk_rec(1'b0, 22'd44, 16'hFFFF, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd45, 16'hFFFE, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0, '0);
        // sex selector 3 never matches
        add_cfg(REG_LOCATION_FILTER, 32'd0);
        add_cfg(REG_CATEGORY_MATCH, 32'd3);
        add_rec(mk_rec(1'b1, 22'd46, 16'd1, 8'd50, 1'b1, 2'd3, 2'd3, 1'b1, 2'd3, 0),
                1'b1, '0);
        // every category term at its strictest
        add_cfg(REG_CATEGORY_MATCH, 32'h1FD);
        add_rec(mk_rec(1'b0, 22'd47, 16'd1, 8'd50, 1'b1, 2'd3, 2'd3, 1'b1, 2'd3, 0),
                1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd48, 16'd1, 8'd50, 1'b1, 2'd3, 2'd2, 1'b1, 2'd3, 0),
                1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd49, 16'd1, 8'd50, 1'b1, 2'd3, 2'd3, 1'b1, 2'd2, 0),
                1'b0, '0);
        add_cfg(REG_CATEGORY_MATCH, 32'd2);
        add_cfg(REG_INTEREST_INDEX, 32'd319);
        add_rec(mk_rec(1'b0, 22'd50, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 32'h8000_0000),
                1'b0, '0);
        add_rec(mk_rec(1'b0, 22'd51, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 32'h7FFF_FFFF),
                1'b0, '0);
        // interest index past the interest set
        add_cfg(REG_INTEREST_INDEX, 32'd320);
        add_rec(mk_rec(1'b1, 22'd52, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 32'hFFFF_FFFF),
                1'b1, '0);
        add_cfg(REG_INTEREST_INDEX, 32'd1);
        add_rec(mk_rec(1'b0, 22'd53, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 32'h2), 1'b0, '0);
        // paging: zero page, skip boundary, page full, skip at max
        add_cfg(REG_INTEREST_INDEX, 32'd0);
        add_cfg(REG_PAGE_LIMIT, 32'd0);
        add_rec(mk_rec(1'b1, 22'd54, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b0, 0, 1, 0));
        add_cfg(REG_PAGE_LIMIT, 32'd1);
        add_cfg(REG_SKIP_COUNT, 32'd2);
        add_rec(mk_rec(1'b1, 22'd55, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b0, 0, 1, 0));
        add_rec(mk_rec(1'b0, 22'd56, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b1, 22'd56, 2, 1));
        add_rec(mk_rec(1'b0, 22'd57, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b0, 0, 3, 1));
        add_cfg(REG_SKIP_COUNT, 32'h3FFFFF);
        add_rec(mk_rec(1'b1, 22'd58, 16'd1, 8'd50, 1'b0, 0, 0, 1'b0, 0, 0),
                1'b1, mk_res(1'b1, 1'b0, 0, 1, 0));
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // register write followed by a readback, both while the block is idle
    task automatic cfg_write(t_reg_idx idx, logic [31:0] field);
        logic [31:0] mask;
        logic [31:0] pw;
        case (idx)
            REG_AGE_LOW, REG_AGE_HIGH:              mask = 32'hFF;
            REG_LOCATION_FILTER:                    mask = 32'hFFFF;
            REG_CATEGORY_MATCH, REG_INTEREST_INDEX: mask = 32'h1FF;
            REG_SKIP_COUNT:                         mask = 32'h3F_FFFF;
            REG_PAGE_LIMIT:                         mask = 32'h3F;
            default:                                mask = 32'h0;
        endcase
        // junk above the register width must be dropped
        pw = (field & mask) | ($urandom() & ~mask);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= pw;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_AGE_LOW:         cfg.age_low         = pw[7:0];
            REG_AGE_HIGH:        cfg.age_high        = pw[7:0];
            REG_LOCATION_FILTER: cfg.location_filter = pw[15:0];
            REG_CATEGORY_MATCH:  cfg.category_match  = pw[8:0];
            REG_INTEREST_INDEX:  cfg.interest_index  = pw[8:0];
            REG_SKIP_COUNT:      cfg.skip_count      = pw[21:0];
            REG_PAGE_LIMIT:      cfg.page_limit      = pw[5:0];
            default: ;
        endcase
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("prdata", pw & mask, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic settle();
        rec_if.valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic rand_config(bit loose);
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [15:0] loc;
        logic [8:0]  cat;
        logic [8:0]  intr;
        logic [21:0] skip;
        logic [5:0]  page;
        int          k;
        if (loose) begin
            // everything matches and long scans, so the page clamp is reached
            lo = 0; hi = 255; loc = 0; cat = {7'd0, SEX_ANY}; intr = 0; skip = 0; page = 63;
        end else begin
            lo   = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 60));
            hi   = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 255));
            loc  = ($urandom_range(0, 1) == 0) ? 16'd0 :
                   ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            cat  = 9'($urandom());
            cat[1:0] = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            k    = $urandom_range(0, 5);
            intr = (k < 2) ? 9'd0 : (k == 2) ? 9'd319 :
                   (k == 3) ? 9'($urandom_range(320, 511)) : 9'($urandom_range(1, 318));
            skip = ($urandom_range(0, 7) == 0) ? 22'h3FFFFF : 22'($urandom_range(0, 30));
            page = 6'($urandom());
        end
        cfg_write(REG_AGE_LOW, 32'(lo));
        cfg_write(REG_AGE_HIGH, 32'(hi));
        cfg_write(REG_LOCATION_FILTER, 32'(loc));
        cfg_write(REG_CATEGORY_MATCH, 32'(cat));
        cfg_write(REG_INTEREST_INDEX, 32'(intr));
        cfg_write(REG_SKIP_COUNT, 32'(skip));
        cfg_write(REG_PAGE_LIMIT, 32'(page));
    endtask

    // record built to pass the current filter, then in some cases fields knocked off
    function automatic t_rec aimed_record(bit loose);
        t_rec       r;
        logic [1:0] ws;
        int         n;
        int         k;
        r.first_record  = loose ? ($urandom_range(0, 79) == 0) : ($urandom_range(0, 24) == 0);
        r.user_id       = ID_BITS'($urandom());
        r.user_location = (cfg.location_filter != 0) ? cfg.location_filter : 16'($urandom());
        r.user_age      = (cfg.age_low <= cfg.age_high) ?
                          8'($urandom_range(cfg.age_high, cfg.age_low)) : 8'($urandom());
        ws              = cfg.category_match[1:0];
        r.user_sex      = (ws < SEX_ANY) ? ws[0] : 1'($urandom());
        r.user_active   = 2'($urandom_range(3, cfg.category_match[5:4]));
        r.user_pic      = 2'($urandom_range(3, cfg.category_match[7:6]));
        r.user_single   = cfg.category_match[8] | 1'($urandom());
        r.user_orientation = (cfg.category_match[3:2] != ORI_ANY) ?
                             cfg.category_match[3:2] : 2'($urandom());
        r.interest_word = $urandom();
        if (cfg.interest_index != 0)
            r.interest_word[cfg.interest_index % WORD_BITS] = 1'b1;
        k = $urandom_range(0, 9);
        n = (k < 6) ? 0 : (k < 9) ? 1 : 4;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: r.user_location    = 16'($urandom());
                1: r.user_age         = 8'($urandom());
                2: r.user_sex         = ~r.user_sex;
                3: r.user_active      = 2'($urandom());
                4: r.user_pic         = 2'($urandom());
                5: r.user_single      = 1'($urandom());
                6: r.user_orientation = 2'($urandom());
                default: r.interest_word = $urandom();
            endcase
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_rec(t_rec r, bit typed, t_res res);
        int      gap;
        t_pinned pin;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                rec_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        pin.typed = typed;
        pin.res   = res;
        pinned_results.push_back(pin);
        rec_if.data  <= r;
        rec_if.valid <= 1'b1;
        do @(posedge i_clk); while (!rec_if.ready);
        @(negedge i_clk);
    endtask

    // receiver: ready runs broken by stalls of random length
    int rx_left;
    bit rx_on;
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            if (rx_on && $urandom_range(0, 3) != 0) begin
                rx_on   = 1'b0;
                rx_left = $urandom_range(1, 8);
            end else begin
                rx_on   = 1'b1;
                rx_left = $urandom_range(1, 30);
            end
        end else begin
            rx_left--;
        end
        res_if.ready <= rx_on;
    end

    always @(posedge i_clk) begin
        t_res    got;
        t_res    want;
        t_pinned pin;
        if (i_rst_n) begin
            if (rec_if.valid && rec_if.ready) begin
                want = filter_record(rec_if.data);
                pin  = pinned_results.pop_front();
                results_due.push_back(pin.typed ? pin.res : want);
            end
            if (res_if.valid === 1'b1 && res_if.ready) begin
                got = res_if.data;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, got);
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("matched", 32'(want.matched), 32'(got.matched));
                    check_field("emit", 32'(want.emit), 32'(got.emit));
                    check_field("result_id", 32'(want.result_id), 32'(got.result_id));
                    check_field("total_matched", 32'(want.total_matched),
                                32'(got.total_matched));
                    check_field("returned_count", 32'(want.returned_count),
                                32'(got.returned_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("tb_record_filter_pager_unit: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rec_if.valid = 1'b0;
        rec_if.data  = '0;
        res_if.ready = 1'b0;
        rx_on        = 1'b0;
        rx_left      = 0;
        burst_left   = 0;
        errors       = 0;
        cyc_cnt      = 0;
        cfg = '{age_low: 8'd0, age_high: 8'd255, location_filter: 16'd0,
                category_match: 9'd2, interest_index: 9'd0, skip_count: 22'd0,
                page_limit: 6'd25};
        match_count   = '0;
        emitted_count = '0;
        build_table();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].val);
            end else begin
                send_rec(dir_rows[i].rec, dir_rows[i].typed, dir_rows[i].res);
            end
        end
        for (int p = 0; p < 9; p++) begin
            settle();
            rand_config(p == 0);
            repeat (100) send_rec(aimed_record(p == 0), 1'b0, '0);
        end
        settle();
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("tb_record_filter_pager_unit: PASS");
        else
            $display("tb_record_filter_pager_unit: FAIL");
        $finish;
    end

endmodule
